FILE: src/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_NOW(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define CHK_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define CHK_NOW(lbl, clk, rst, a, b)
`define CHK_NEXT(lbl, clk, rst, a, b)
`endif
`endif

FILE: src/ptt_pkg.sv
`timescale 1ns / 1ps
package ptt_pkg;

  localparam int K_W = 6;
  localparam int CNT_W = 7;
  localparam int N_W = 6;
  localparam int DIV_W = 32;

  localparam logic [2:0] CMD_RECT    = 3'd0;
  localparam logic [2:0] CMD_OUTLINE = 3'd1;
  localparam logic [2:0] CMD_LINE    = 3'd2;
  localparam logic [2:0] CMD_CIRCLE  = 3'd3;
  localparam logic [2:0] CMD_PIE     = 3'd4;
  localparam logic [2:0] CMD_RING    = 3'd5;
  localparam logic [2:0] CMD_SLICE   = 3'd6;
  localparam logic [2:0] CMD_CLEAR   = 3'd7;

  typedef enum logic [1:0] {
    OP_VERT,
    OP_LDXY,
    OP_LEND
  } op_t;

  typedef struct packed {
    logic capture;
    logic setup;
    logic div_go;
    logic acc_adv;
    logic st_a;
    logic st_r;
    logic st_b;
    logic st_c;
    logic last;
    op_t op;
    logic [K_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic [2:0] prim;
    logic [K_W-1:0] cnt_m1;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic int sine_entry(int k, int bits);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned s;
    int q;
    int v;
    q = (k >> (bits - 2)) & 3;
    u = longint'(k & ((1 << (bits - 2)) - 1)) << (32 - bits);
    if ((q & 1) != 0) u = (64'd1 << 30) - u;
    u2 = (u * u) >> 30;
    s = 61;
    s = 3864 - ((s * u2) >> 30);
    s = 172272 - ((s * u2) >> 30);
    s = 5026995 - ((s * u2) >> 30);
    s = 85569306 - ((s * u2) >> 30);
    s = 693598668 - ((s * u2) >> 30);
    s = 1686629713 - ((s * u2) >> 30);
    s = (s * u) >> 30;
    v = int'((s + 8192) >> 14);
    return ((q & 2) != 0) ? -v : v;
  endfunction

endpackage

FILE: src/ptt_divider.sv
`timescale 1ns / 1ps
module ptt_divider import ptt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [N_W-1:0]   divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [N_W-1:0]   remainder
);

  logic busy;
  logic [4:0] count;
  logic [DIV_W-1:0] quo;
  logic [N_W-1:0] rem;
  logic [N_W:0] trial;
  logic [N_W:0] diff;
  logic ge;

  assign trial = {rem, quo[DIV_W-1]};
  assign ge = trial >= {1'b0, divisor};
  assign diff = trial - {1'b0, divisor};
  assign quotient = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      count <= '0;
    end else if (busy) begin
      count <= count + 5'd1;
      if (count == 5'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], ge};
      rem <= ge ? diff[N_W-1:0] : trial[N_W-1:0];
    end
  end

endmodule

FILE: src/ptt_datapath.sv
`timescale 1ns / 1ps
module ptt_datapath import ptt_pkg::*; #(
  parameter int SEGMENTS_MAX = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            st,
  input  logic [2:0]         command,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] param_a,
  input  logic signed [31:0] param_b,
  input  logic signed [31:0] param_c,
  input  logic signed [31:0] param_d,
  input  logic [7:0]         segments,
  input  logic [7:0]         red_in,
  input  logic [7:0]         green_in,
  input  logic [7:0]         blue_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               has_vertex,
  output logic signed [31:0] vertex_x,
  output logic signed [31:0] vertex_y,
  output logic [7:0]         red_out,
  output logic [7:0]         green_out,
  output logic [7:0]         blue_out,
  output logic               has_triangle,
  output logic [31:0]        corner_a,
  output logic [31:0]        corner_b,
  output logic [31:0]        corner_c,
  output logic               last_of_primitive
);

  localparam int TabSize = 1 << SINE_TABLE_BITS;
  localparam int Quarter = TabSize / 4;
  localparam int IxLo = 16 - SINE_TABLE_BITS;
  localparam int B = SINE_TABLE_BITS;

  logic signed [17:0] sine_rom [TabSize];

  for (genvar gi = 0; gi < TabSize; gi++) begin : g_sine
    localparam int Entry = sine_entry(gi, SINE_TABLE_BITS);
    assign sine_rom[gi] = 18'(Entry);
  end

  logic [2:0] prim;
  logic [31:0] px, py, pa, pb, pc, pd;
  logic [N_W-1:0] nseg;
  logic [7:0] red, green, blue;
  logic [N_W-1:0] nsat;

  logic [31:0] tsum, xo, yo, yb, xr, amag;
  logic signed [32:0] r0, r1;
  logic aneg;
  logic [CNT_W-1:0] nv, nt, nv_next, nt_next;
  logic [K_W-1:0] cnt_m1;
  logic [32:0] half_b;

  logic [31:0] ex, ey, dx, dy;
  logic [31:0] vertex_base;

  logic full_mode;
  logic div_done;
  logic [DIV_W-1:0] div_quo;
  logic [N_W-1:0] div_rem;
  logic [N_W-1:0] divisor;
  logic [DIV_W-1:0] dividend;
  logic [31:0] acc_q;
  logic [N_W-1:0] acc_r;
  logic [N_W:0] r_sum;
  logic r_wrap;
  logic adv_cond;

  logic [B-1:0] ix_sel, ix_a;
  logic [31:0] slice_sum;
  logic [31:0] bx_c, by_c, ox_c, oy_c;
  logic [31:0] bx, by, ox, oy;
  logic [31:0] rx, ry, rw, rh;
  logic polar_c, polar;
  logic sh17_c, sh17;
  logic signed [32:0] m_c, m_a;
  logic hv_c, hv, ht_c, ht;
  logic [CNT_W-1:0] k7, n7, n2;
  logic [CNT_W-1:0] ta_c, tb_c, tc_c, oo;
  logic [K_W-1:0] ta, tb, tc;

  logic signed [17:0] sin_r, cos_r;
  logic signed [49:0] prod_s, prod_c;
  logic signed [49:0] half50, ts, tc50;
  logic [31:0] rs, rc, xoff, yoff, vx, vy;
  logic load_out;

  assign nsat = (segments < 8'd3) ? N_W'(3) :
                (segments > 8'(SEGMENTS_MAX)) ? N_W'(SEGMENTS_MAX) : segments[N_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prim <= command;
      px <= pos_x;
      py <= pos_y;
      pa <= param_a;
      pb <= param_b;
      pc <= param_c;
      pd <= param_d;
      nseg <= nsat;
      red <= red_in;
      green <= green_in;
      blue <= blue_in;
    end
  end

  assign n7 = {1'b0, nseg};
  assign n2 = {nseg, 1'b0};
  assign half_b = {pb[31], pb[31], pb[31:1]};

  always_comb begin
    nv_next = 7'd4;
    nt_next = 7'd2;
    case (prim)
      CMD_OUTLINE: begin
        nv_next = 7'd16;
        nt_next = 7'd8;
      end
      CMD_CIRCLE: begin
        nv_next = n7 + 7'd1;
        nt_next = n7;
      end
      CMD_PIE: begin
        nv_next = n7 + 7'd1;
        nt_next = n7 - 7'd1;
      end
      CMD_RING: begin
        nv_next = n2;
        nt_next = n2;
      end
      CMD_SLICE: begin
        nv_next = n2;
        nt_next = n2 - 7'd2;
      end
      default: begin
        nv_next = 7'd4;
        nt_next = 7'd2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      tsum <= pc + pd;
      xo <= px - pd;
      yo <= py - pd;
      yb <= py + pb - pc;
      xr <= px + pa - pc;
      r0 <= $signed({pa[31], pa}) - $signed(half_b);
      r1 <= $signed({pa[31], pa}) + $signed(half_b);
      amag <= pd[31] ? (~pd + 32'd1) : pd;
      aneg <= pd[31];
      nv <= nv_next;
      nt <= nt_next;
      cnt_m1 <= K_W'(nv_next - 7'd1);
    end
  end

  assign full_mode = (prim == CMD_CIRCLE) || (prim == CMD_RING);
  assign divisor = full_mode ? nseg : nseg - N_W'(1);
  assign dividend = full_mode ? DIV_W'(TabSize) : amag;

  ptt_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_go),
    .dividend  (dividend),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign r_sum = {1'b0, acc_r} + {1'b0, div_rem};
  assign r_wrap = r_sum >= {1'b0, divisor};
  assign adv_cond = ((prim == CMD_CIRCLE || prim == CMD_PIE) && cmd.k != '0) ||
                    ((prim == CMD_RING || prim == CMD_SLICE) && cmd.k[0]);

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      acc_q <= '0;
      acc_r <= '0;
    end else if (cmd.acc_adv && adv_cond) begin
      acc_r <= r_wrap ? N_W'(r_sum - {1'b0, divisor}) : r_sum[N_W-1:0];
      acc_q <= acc_q + div_quo + {31'd0, r_wrap};
    end
  end

  assign slice_sum = aneg ? (pc - acc_q) : (pc + acc_q);
  assign k7 = {1'b0, cmd.k};

  always_comb begin
    rx = px;
    ry = py;
    rw = pa;
    rh = pb;
    if (prim == CMD_OUTLINE) begin
      case (cmd.k[3:2])
        2'd0: begin
          rx = xo;
          rw = tsum;
        end
        2'd1: begin
          ry = yo;
          rh = tsum;
        end
        2'd2: begin
          ry = yb;
          rh = tsum;
        end
        default: begin
          rx = xr;
          rw = tsum;
        end
      endcase
    end
  end

  always_comb begin
    ix_sel = full_mode ? acc_q[B-1:0] : slice_sum[15:IxLo];
    bx_c = px;
    by_c = py;
    ox_c = '0;
    oy_c = '0;
    polar_c = 1'b0;
    sh17_c = 1'b0;
    m_c = $signed({pa[31], pa});
    case (cmd.op)
      OP_LDXY: begin
        ix_sel = pd[15:IxLo];
        polar_c = 1'b1;
        sh17_c = 1'b1;
        m_c = $signed({pb[31], pb});
      end
      OP_LEND: begin
        ix_sel = pd[15:IxLo];
        polar_c = 1'b1;
      end
      default: begin
        case (prim)
          CMD_RECT, CMD_OUTLINE: begin
            bx_c = rx;
            by_c = ry;
            ox_c = (cmd.k[1:0] == 2'd1 || cmd.k[1:0] == 2'd2) ? rw : '0;
            oy_c = cmd.k[1] ? rh : '0;
          end
          CMD_LINE: begin
            bx_c = cmd.k[1] ? ex : px;
            by_c = cmd.k[1] ? ey : py;
            if (cmd.k[1:0] == 2'd0 || cmd.k[1:0] == 2'd3) begin
              ox_c = -dx;
              oy_c = dy;
            end else begin
              ox_c = dx;
              oy_c = -dy;
            end
          end
          CMD_CIRCLE, CMD_PIE: begin
            polar_c = cmd.k != '0;
          end
          CMD_RING, CMD_SLICE: begin
            polar_c = 1'b1;
            m_c = cmd.k[0] ? r1 : r0;
          end
          default: begin
            polar_c = 1'b0;
          end
        endcase
      end
    endcase
  end

  always_comb begin
    oo = {3'b000, cmd.k[2:1], 2'b00};
    ta_c = 7'd0;
    tb_c = 7'd1;
    tc_c = 7'd2;
    case (prim)
      CMD_RECT, CMD_LINE: begin
        if (cmd.k[0]) begin
          ta_c = 7'd2;
          tb_c = 7'd3;
          tc_c = 7'd0;
        end
      end
      CMD_OUTLINE: begin
        if (cmd.k[0]) begin
          ta_c = oo + 7'd2;
          tb_c = oo + 7'd3;
          tc_c = oo;
        end else begin
          ta_c = oo;
          tb_c = oo + 7'd1;
          tc_c = oo + 7'd2;
        end
      end
      CMD_CIRCLE, CMD_PIE: begin
        ta_c = 7'd0;
        if (prim == CMD_CIRCLE && k7 == n7 - 7'd1) begin
          tb_c = n7;
          tc_c = 7'd1;
        end else begin
          tb_c = k7 + 7'd1;
          tc_c = k7 + 7'd2;
        end
      end
      CMD_RING, CMD_SLICE: begin
        if (prim == CMD_RING && k7 >= n2 - 7'd2) begin
          if (cmd.k[0]) begin
            ta_c = 7'd1;
            tb_c = 7'd0;
            tc_c = n2 - 7'd2;
          end else begin
            ta_c = n2 - 7'd2;
            tb_c = n2 - 7'd1;
            tc_c = 7'd1;
          end
        end else if (cmd.k[0]) begin
          ta_c = k7 + 7'd2;
          tb_c = k7 + 7'd1;
          tc_c = k7 - 7'd1;
        end else begin
          ta_c = k7;
          tb_c = k7 + 7'd1;
          tc_c = k7 + 7'd3;
        end
      end
      default: begin
        ta_c = 7'd0;
      end
    endcase
  end

  assign hv_c = k7 < nv;
  assign ht_c = k7 < nt;

  always_ff @(posedge clk) begin
    if (cmd.st_a) begin
      ix_a <= ix_sel;
      bx <= bx_c;
      by <= by_c;
      ox <= ox_c;
      oy <= oy_c;
      polar <= polar_c;
      sh17 <= sh17_c;
      m_a <= m_c;
      hv <= hv_c;
      ht <= ht_c;
      ta <= ta_c[K_W-1:0];
      tb <= tb_c[K_W-1:0];
      tc <= tc_c[K_W-1:0];
    end
    if (cmd.st_r) begin
      sin_r <= sine_rom[ix_a];
      cos_r <= sine_rom[ix_a + B'(Quarter)];
    end
    if (cmd.st_b) begin
      prod_s <= m_a * sin_r;
      prod_c <= m_a * cos_r;
    end
  end

  assign half50 = sh17 ? 50'sd65536 : 50'sd32768;
  assign ts = prod_s + half50;
  assign tc50 = prod_c + half50;
  assign rs = sh17 ? ts[48:17] : ts[47:16];
  assign rc = sh17 ? tc50[48:17] : tc50[47:16];
  assign xoff = polar ? rc : ox;
  assign yoff = polar ? rs : oy;
  assign vx = bx + xoff;
  assign vy = by + yoff;

  assign st.out_free = !out_valid || !out_stall;
  assign load_out = cmd.st_c && (cmd.op == OP_VERT) && st.out_free;

  always_ff @(posedge clk) begin
    if (cmd.st_c && cmd.op == OP_LDXY) begin
      dx <= rs;
      dy <= rc;
    end
    if (cmd.st_c && cmd.op == OP_LEND) begin
      ex <= vx;
      ey <= vy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      vertex_base <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.capture && command == CMD_CLEAR) begin
        vertex_base <= '0;
      end else if (load_out && cmd.last) begin
        vertex_base <= vertex_base + {25'd0, nv};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      has_vertex <= hv;
      vertex_x <= hv ? vx : '0;
      vertex_y <= hv ? vy : '0;
      red_out <= hv ? red : '0;
      green_out <= hv ? green : '0;
      blue_out <= hv ? blue : '0;
      has_triangle <= ht;
      corner_a <= ht ? vertex_base + {26'd0, ta} : '0;
      corner_b <= ht ? vertex_base + {26'd0, tb} : '0;
      corner_c <= ht ? vertex_base + {26'd0, tc} : '0;
      last_of_primitive <= cmd.last;
    end
  end

  assign st.prim = prim;
  assign st.cnt_m1 = cnt_m1;
  assign st.div_done = div_done;

endmodule

FILE: src/ptt_ctrl.sv
`timescale 1ns / 1ps
module ptt_ctrl import ptt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_A,
    S_R,
    S_B,
    S_C
  } state_t;

  state_t state;
  op_t op;
  logic [K_W-1:0] k;
  logic last;

  assign last = k == st.cnt_m1;
  assign in_stall = state != S_IDLE;

  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.setup = state == S_SETUP;
  assign cmd.div_go = state == S_DIV_GO;
  assign cmd.acc_adv = (state == S_C) && (op == OP_VERT) && st.out_free && !last;
  assign cmd.st_a = state == S_A;
  assign cmd.st_r = state == S_R;
  assign cmd.st_b = state == S_B;
  assign cmd.st_c = state == S_C;
  assign cmd.last = last;
  assign cmd.op = op;
  assign cmd.k = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_VERT;
      k <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          k <= '0;
          op <= OP_VERT;
          case (st.prim)
            CMD_RECT, CMD_OUTLINE: state <= S_A;
            CMD_LINE: begin
              op <= OP_LDXY;
              state <= S_A;
            end
            CMD_CLEAR: state <= S_IDLE;
            default: state <= S_DIV_GO;
          endcase
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (st.div_done) begin
            state <= S_A;
          end
        end
        S_A: state <= S_R;
        S_R: state <= S_B;
        S_B: state <= S_C;
        S_C: begin
          case (op)
            OP_LDXY: begin
              op <= OP_LEND;
              state <= S_A;
            end
            OP_LEND: begin
              op <= OP_VERT;
              k <= '0;
              state <= S_A;
            end
            default: begin
              if (st.out_free) begin
                if (last) begin
                  state <= S_IDLE;
                end else begin
                  k <= k + K_W'(1);
                  state <= S_A;
                end
              end
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/primitive_triangle_tessellator_top.sv
// Turns one 2D primitive word into a stream of vertex and triangle words, one result word
// per vertex slot, with triangle corners offset by a running vertex base that a clear word
// resets. Items are handled one at a time: a clear ends after its setup step, a rectangle
// or outline goes from setup straight to its results, a line first works out its
// half-thickness offsets and end point, and the arc shapes wait while the shared serial
// divider splits the angle step. Every result then passes through index, sine table read,
// multiply and add stages, and holds in the add stage while the output is stalled.
// A new item is taken while the last result word still waits in the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module primitive_triangle_tessellator_top import ptt_pkg::*; #(
  parameter int SEGMENTS_MAX = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] param_a,
  input  logic signed [31:0] param_b,
  input  logic signed [31:0] param_c,
  input  logic signed [31:0] param_d,
  input  logic [7:0]         segments,
  input  logic [7:0]         red_in,
  input  logic [7:0]         green_in,
  input  logic [7:0]         blue_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               has_vertex,
  output logic signed [31:0] vertex_x,
  output logic signed [31:0] vertex_y,
  output logic [7:0]         red_out,
  output logic [7:0]         green_out,
  output logic [7:0]         blue_out,
  output logic               has_triangle,
  output logic [31:0]        corner_a,
  output logic [31:0]        corner_b,
  output logic [31:0]        corner_c,
  output logic               last_of_primitive
);

  cmd_t ccmd;
  status_t cstat;

  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (cstat),
    .cmd      (ccmd)
  );

  ptt_datapath #(
    .SEGMENTS_MAX    (SEGMENTS_MAX),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (ccmd),
    .st                (cstat),
    .command           (command),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .param_a           (param_a),
    .param_b           (param_b),
    .param_c           (param_c),
    .param_d           (param_d),
    .segments          (segments),
    .red_in            (red_in),
    .green_in          (green_in),
    .blue_in           (blue_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .has_vertex        (has_vertex),
    .vertex_x          (vertex_x),
    .vertex_y          (vertex_y),
    .red_out           (red_out),
    .green_out         (green_out),
    .blue_out          (blue_out),
    .has_triangle      (has_triangle),
    .corner_a          (corner_a),
    .corner_b          (corner_b),
    .corner_c          (corner_c),
    .last_of_primitive (last_of_primitive)
  );

  `CHK_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `CHK_NOW(a_clear_returns, clk, rst, in_valid && !in_stall && command == CMD_CLEAR, ##2 !in_stall)
  `CHK_NOW(a_one_stage, clk, rst, 1'b1, $onehot0({ccmd.setup, ccmd.st_a, ccmd.st_r, ccmd.st_b, ccmd.st_c}))
  `CHK_NEXT(a_adv_with_load, clk, rst, ccmd.acc_adv, out_valid)

endmodule
